// ----- hdl/witness_slot_table_macros.svh -----
// Assertion macros for the witness slot table.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef WITNESS_SLOT_TABLE_MACROS_SVH
`define WITNESS_SLOT_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define WST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/wst_pkg.sv -----
// Shared types and codes for the witness slot table.
// No dependencies; imported by every other file but the assertion macros.
package wst_pkg;

    localparam int SLOTS_DEF = 64;

    localparam int ID_W     = 32;
    localparam int TIME_W   = 64;
    localparam int KIND_W   = 4;
    localparam int PHASE_W  = 2;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    // request types
    localparam logic [REQ_W-1:0] REQ_CREATE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK             = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_TRANSITION = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED      = 2'd3;

    localparam logic [PHASE_W-1:0] PH_REQUESTED = 2'd0;

    // request as seen by every cell during a scan
    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [ID_W-1:0]    witness_id;
        logic [PHASE_W-1:0] target_phase;
        logic [KIND_W-1:0]  reason_kind;
        logic [TIME_W-1:0]  reason_time;
        logic [ID_W-1:0]    reason_region;
        logic [ID_W-1:0]    reason_task;
        logic [ID_W-1:0]    ident;
    } bcast_t;

    // partial result handed from cell to cell
    typedef struct packed {
        logic               hit;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]    new_id;
        logic [PHASE_W-1:0] cur_phase;
        logic [KIND_W-1:0]  out_kind;
        logic [TIME_W-1:0]  out_time;
        logic [ID_W-1:0]    out_region;
        logic [ID_W-1:0]    out_task;
    } res_t;

    // final response
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]    new_id;
        logic [PHASE_W-1:0] cur_phase;
        logic [KIND_W-1:0]  out_kind;
        logic [TIME_W-1:0]  out_time;
        logic [ID_W-1:0]    out_region;
        logic [ID_W-1:0]    out_task;
        logic               found;
    } rsp_t;

endpackage

// ----- hdl/wst_req_if.sv -----
// Request channel of the witness slot table: valid/ready plus payload.
// Depends on wst_pkg.
interface wst_req_if
    import wst_pkg::*;
    ();

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [ID_W-1:0]    witness_id;
    logic [PHASE_W-1:0] target_phase;
    logic [KIND_W-1:0]  reason_kind;
    logic [TIME_W-1:0]  reason_time;
    logic [ID_W-1:0]    reason_region;
    logic [ID_W-1:0]    reason_task;

    modport source (
        output valid, req_type, witness_id, target_phase,
               reason_kind, reason_time, reason_region, reason_task,
        input  ready
    );

    modport sink (
        input  valid, req_type, witness_id, target_phase,
               reason_kind, reason_time, reason_region, reason_task,
        output ready
    );

endinterface

// ----- hdl/wst_rsp_if.sv -----
// Response channel of the witness slot table: valid/ready plus payload.
// Depends on wst_pkg.
interface wst_rsp_if
    import wst_pkg::*;
    ();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     new_id;
    logic [PHASE_W-1:0]  cur_phase;
    logic [KIND_W-1:0]   out_kind;
    logic [TIME_W-1:0]   out_time;
    logic [ID_W-1:0]     out_region;
    logic [ID_W-1:0]     out_task;
    logic                found;

    modport source (
        output valid, status, new_id, cur_phase, out_kind,
               out_time, out_region, out_task, found,
        input  ready
    );

    modport sink (
        input  valid, status, new_id, cur_phase, out_kind,
               out_time, out_region, out_task, found,
        output ready
    );

endinterface

// ----- hdl/wst_cell.sv -----
// One witness slot: holds its entry and acts on the scan token as it passes.
// Depends on wst_pkg.
module wst_cell
    import wst_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  bcast_t bc,
    input  logic   live_in,
    input  res_t   res_in,
    output logic   live_out,
    output res_t   res_out
);

    logic               active_reg;
    logic               active_next;
    logic [ID_W-1:0]    ident_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [ID_W-1:0]    region_reg;
    logic [ID_W-1:0]    task_reg;
    logic               live_reg;
    res_t               res_reg;
    res_t               res_next;
    logic               wr_create;
    logic               wr_phase;

    always_comb
    begin
        res_next    = res_in;
        active_next = active_reg;
        wr_create   = 1'b0;
        wr_phase    = 1'b0;
        // a request already served further up the row passes untouched
        if (live_in && !res_in.hit)
        begin
            if (bc.req_type == REQ_CREATE)
            begin
                if (!active_reg)
                begin
                    wr_create       = 1'b1;
                    active_next     = 1'b1;
                    res_next.hit    = 1'b1;
                    res_next.status = ST_OK;
                    res_next.new_id = bc.ident;
                end
            end
            else if (active_reg && ident_reg == bc.witness_id)
            begin
                res_next.hit = 1'b1;
                case (bc.req_type)
                    REQ_ADVANCE:
                    begin
                        if (bc.target_phase <= phase_reg)
                        begin
                            res_next.status = ST_BAD_TRANSITION;
                        end
                        else
                        begin
                            wr_phase        = 1'b1;
                            res_next.status = ST_OK;
                        end
                    end
                    REQ_RELEASE:
                    begin
                        active_next     = 1'b0;
                        res_next.status = ST_OK;
                    end
                    REQ_QUERY:
                    begin
                        res_next.status     = ST_OK;
                        res_next.cur_phase  = phase_reg;
                        res_next.out_kind   = kind_reg;
                        res_next.out_time   = time_reg;
                        res_next.out_region = region_reg;
                        res_next.out_task   = task_reg;
                    end
                    default:
                    begin
                        res_next.hit = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            live_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            live_reg   <= live_in;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (wr_create)
        begin
            ident_reg  <= bc.ident;
            phase_reg  <= PH_REQUESTED;
            kind_reg   <= bc.reason_kind;
            time_reg   <= bc.reason_time;
            region_reg <= bc.reason_region;
            task_reg   <= bc.reason_task;
        end
        else if (wr_phase)
        begin
            phase_reg <= bc.target_phase;
        end
    end

    assign live_out = live_reg;
    assign res_out  = res_reg;

endmodule

// ----- hdl/wst_chain.sv -----
// Row of slot cells; the scan token enters at slot 0 and leaves after the last.
// Depends on wst_pkg and wst_cell.
module wst_chain
    import wst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  bcast_t bc,
    input  logic   head_live,
    input  res_t   head_res,
    output logic   tail_live,
    output res_t   tail_res
);

    logic live_w [SLOTS+1];
    res_t res_w  [SLOTS+1];

    assign live_w[0] = head_live;
    assign res_w[0]  = head_res;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        wst_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bc       (bc),
            .live_in  (live_w[g]),
            .res_in   (res_w[g]),
            .live_out (live_w[g+1]),
            .res_out  (res_w[g+1])
        );
    end

    assign tail_live = live_w[SLOTS];
    assign tail_res  = res_w[SLOTS];

endmodule

// ----- hdl/witness_slot_table.sv -----
// Witness slot table top level: request latch, scan control, id counter, response.
// Depends on wst_pkg, wst_req_if, wst_rsp_if, wst_chain and the assertion macros.
// A request is registered, launched through a start register and the row of slot cells,
// and its result is registered for the response; a new request waits until the token has left the row.
// A request may be accepted while the previous response still waits; input stalls
// once a second response is held. Reset clears all slot active bits at once and sets
// the next id to 1; no clearing pass.
`include "witness_slot_table_macros.svh"

module witness_slot_table
    import wst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    wst_req_if.sink   req,
    wst_rsp_if.source rsp
);

    typedef enum logic {S_IDLE, S_SCAN} state_t;

    state_t          state_reg;
    logic            start_live_reg;
    logic            rsp_valid_reg;
    logic            hold_full_reg;
    logic [ID_W-1:0] next_ident_reg;
    logic [ID_W-1:0] ident_inc;
    bcast_t          req_reg;
    bcast_t          bc;
    rsp_t            out_reg;
    rsp_t            hold_reg;
    rsp_t            fin;
    logic            tail_live;
    res_t            tail_res;
    logic            accept;
    logic            out_take;
    logic            scan_done;
    logic            load_fin_out;
    logic            load_fin_hold;
    logic            load_hold_out;

    assign req.ready = (state_reg == S_IDLE) && !hold_full_reg;
    assign accept    = req.valid && req.ready;
    assign out_take  = rsp_valid_reg && rsp.ready;
    assign scan_done = (state_reg == S_SCAN) && tail_live;

    assign load_fin_out  = scan_done && (!rsp_valid_reg || out_take);
    assign load_fin_hold = scan_done && rsp_valid_reg && !out_take;
    assign load_hold_out = out_take && hold_full_reg;

    assign ident_inc = next_ident_reg + ID_W'(1);

    always_comb
    begin
        bc       = req_reg;
        bc.ident = next_ident_reg;
    end

    wst_chain #(
        .SLOTS (SLOTS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .bc        (bc),
        .head_live (start_live_reg),
        .head_res  (res_t'('0)),
        .tail_live (tail_live),
        .tail_res  (tail_res)
    );

    // a token that leaves the row unserved means no free slot or no such id
    always_comb
    begin
        fin.status     = tail_res.status;
        fin.new_id     = tail_res.new_id;
        fin.cur_phase  = tail_res.cur_phase;
        fin.out_kind   = tail_res.out_kind;
        fin.out_time   = tail_res.out_time;
        fin.out_region = tail_res.out_region;
        fin.out_task   = tail_res.out_task;
        fin.found      = tail_res.hit && (req_reg.req_type != REQ_CREATE);
        if (!tail_res.hit)
        begin
            fin.status = (req_reg.req_type == REQ_CREATE) ? ST_EXHAUSTED : ST_NOT_FOUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            start_live_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            hold_full_reg  <= 1'b0;
            next_ident_reg <= ID_W'(1);
        end
        else
        begin
            start_live_reg <= accept;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (tail_live)
                    begin
                        state_reg <= S_IDLE;
                        if (tail_res.hit && req_reg.req_type == REQ_CREATE)
                        begin
                            next_ident_reg <= (ident_inc == '0) ? ID_W'(1) : ident_inc;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (load_fin_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (load_fin_hold)
            begin
                hold_full_reg <= 1'b1;
            end
            else if (load_hold_out)
            begin
                hold_full_reg <= 1'b0;
            end
            else if (out_take)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.req_type      <= req.req_type;
            req_reg.witness_id    <= req.witness_id;
            req_reg.target_phase  <= req.target_phase;
            req_reg.reason_kind   <= req.reason_kind;
            req_reg.reason_time   <= req.reason_time;
            req_reg.reason_region <= req.reason_region;
            req_reg.reason_task   <= req.reason_task;
            req_reg.ident         <= '0;
        end
        if (load_fin_out)
        begin
            out_reg <= fin;
        end
        else if (load_hold_out)
        begin
            out_reg <= hold_reg;
        end
        if (load_fin_hold)
        begin
            hold_reg <= fin;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.new_id     = out_reg.new_id;
    assign rsp.cur_phase  = out_reg.cur_phase;
    assign rsp.out_kind   = out_reg.out_kind;
    assign rsp.out_time   = out_reg.out_time;
    assign rsp.out_region = out_reg.out_region;
    assign rsp.out_task   = out_reg.out_task;
    assign rsp.found      = out_reg.found;

    `WST_ASSERT_NEXT(a_accept_starts_token, accept, start_live_reg, "token not launched")
    `WST_ASSERT_NOW(a_tail_only_in_scan, tail_live, state_reg == S_SCAN, "token out of scan")
    `WST_ASSERT_NOW(a_hold_needs_out, hold_full_reg, rsp_valid_reg, "held without output")
    `WST_ASSERT_NOW(a_ident_nonzero, 1'b1, next_ident_reg != '0, "next id is zero")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Testbench for witness_slot_table: directed and random request streams with
// random stalls on both channels, checked against a table model kept here.
// Depends on wst_pkg, wst_req_if, wst_rsp_if and the witness_slot_table RTL.

module tb;
    import wst_pkg::*;

    localparam int TABLE_SLOTS  = SLOTS_DEF;
    localparam int SCAN_LATENCY = TABLE_SLOTS + 1;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 780;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [PHASE_W-1:0] PH_CANCELLING = 2'd1;
    localparam logic [PHASE_W-1:0] PH_FINALIZING = 2'd2;
    localparam logic [PHASE_W-1:0] PH_COMPLETED  = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [ID_W-1:0]    witness_id;
        logic [PHASE_W-1:0] target_phase;
        logic [KIND_W-1:0]  reason_kind;
        logic [TIME_W-1:0]  reason_time;
        logic [ID_W-1:0]    reason_region;
        logic [ID_W-1:0]    reason_task;
    } witness_req_t;

    logic clk;
    logic rst_n;

    wst_req_if req_ch ();
    wst_rsp_if rsp_ch ();

    witness_slot_table #(.SLOTS(TABLE_SLOTS)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // table model
    bit                 tbl_live   [TABLE_SLOTS];
    logic [ID_W-1:0]    tbl_ident  [TABLE_SLOTS];
    logic [PHASE_W-1:0] tbl_phase  [TABLE_SLOTS];
    logic [KIND_W-1:0]  tbl_kind   [TABLE_SLOTS];
    logic [TIME_W-1:0]  tbl_stamp  [TABLE_SLOTS];
    logic [ID_W-1:0]    tbl_region [TABLE_SLOTS];
    logic [ID_W-1:0]    tbl_origin [TABLE_SLOTS];
    int unsigned        tbl_high_water;
    logic [ID_W-1:0]    tbl_next_ident;

    rsp_t            expected_rsp_q [$];
    logic [ID_W-1:0] retired_ids [$];

    int mismatches;
    int rsp_checked;
    int reqs_sent;
    int cycles;
    int burst_left;
    int hold_requests;
    int hold_served;
    int n_create_ok;
    int n_exhausted;
    int n_refused;
    int n_released;
    int n_query_hit;
    int n_missing;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d responses outstanding",
                         cycles, expected_rsp_q.size());
                $display("FAIL witness_slot_table");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- model
    function automatic int find_witness(input logic [ID_W-1:0] id);
        int i;
        if (id == '0)
            return -1;
        for (i = 0; i < TABLE_SLOTS && i < int'(tbl_high_water); i++)
            if (tbl_live[i] && tbl_ident[i] == id)
                return i;
        return -1;
    endfunction

    function automatic rsp_t apply_witness_req(input witness_req_t r);
        rsp_t res;
        int   slot;
        int   i;
        res  = '0;
        slot = -1;
        if (r.req_type == REQ_CREATE)
        begin
            for (i = 0; i < TABLE_SLOTS; i++)
                if (!tbl_live[i])
                begin
                    slot = i;
                    break;
                end
            if (slot < 0)
            begin
                res.status = ST_EXHAUSTED;
                n_exhausted++;
                return res;
            end
            tbl_ident[slot]  = tbl_next_ident;
            tbl_phase[slot]  = PH_REQUESTED;
            tbl_kind[slot]   = r.reason_kind;
            tbl_stamp[slot]  = r.reason_time;
            tbl_region[slot] = r.reason_region;
            tbl_origin[slot] = r.reason_task;
            tbl_live[slot]   = 1'b1;
            tbl_next_ident   = tbl_next_ident + 1'b1;
            if (tbl_next_ident == '0)
                tbl_next_ident = ID_W'(1);
            if (slot >= int'(tbl_high_water))
                tbl_high_water = unsigned'(slot + 1);
            res.status = ST_OK;
            res.new_id = tbl_ident[slot];
            n_create_ok++;
            return res;
        end

        slot = find_witness(r.witness_id);
        if (slot < 0)
        begin
            res.status = ST_NOT_FOUND;
            n_missing++;
            return res;
        end
        res.found = 1'b1;
        res.status = ST_OK;
        if (r.req_type == REQ_ADVANCE)
        begin
            if (r.target_phase <= tbl_phase[slot])
            begin
                res.status = ST_BAD_TRANSITION;
                n_refused++;
            end
            else
                tbl_phase[slot] = r.target_phase;
        end
        else if (r.req_type == REQ_RELEASE)
        begin
            tbl_live[slot] = 1'b0;
            retired_ids.push_back(tbl_ident[slot]);
            n_released++;
        end
        else
        begin
            res.cur_phase  = tbl_phase[slot];
            res.out_kind   = tbl_kind[slot];
            res.out_time   = tbl_stamp[slot];
            res.out_region = tbl_region[slot];
            res.out_task   = tbl_origin[slot];
            n_query_hit++;
        end
        return res;
    endfunction

    function automatic int count_live();
        int i;
        int n;
        n = 0;
        for (i = 0; i < TABLE_SLOTS; i++)
            n += int'(tbl_live[i]);
        return n;
    endfunction

    // random active slot, or -1 on an empty table
    function automatic int pick_live_slot();
        int idx [$];
        int i;
        for (i = 0; i < TABLE_SLOTS; i++)
            if (tbl_live[i])
                idx.push_back(i);
        if (idx.size() == 0)
            return -1;
        return idx[$urandom_range(0, idx.size() - 1)];
    endfunction

    function automatic logic [PHASE_W-1:0] random_phase();
        return PHASE_W'($urandom_range(0, 3));
    endfunction

    function automatic witness_req_t make_req(input logic [REQ_W-1:0] kind_of_req,
                                              input logic [ID_W-1:0] id,
                                              input logic [PHASE_W-1:0] ph);
        witness_req_t r;
        r.req_type      = kind_of_req;
        r.witness_id    = id;
        r.target_phase  = ph;
        r.reason_kind   = KIND_W'($urandom_range(0, 15));
        r.reason_time   = {$urandom, $urandom};
        r.reason_region = $urandom;
        r.reason_task   = $urandom;
        return r;
    endfunction

    function automatic witness_req_t random_witness_req();
        witness_req_t r;
        int live;
        int roll;
        int w_create;
        int w_release;
        int slot;
        logic [ID_W-1:0] id;
        logic [PHASE_W-1:0] ph;
        live      = count_live();
        roll      = $urandom_range(0, 99);
        w_create  = (live < 8) ? 50 : (live > 56) ? 15 : 30;
        w_release = (live > 56) ? 30 : 15;
        slot      = pick_live_slot();
        id        = (slot < 0) ? $urandom : tbl_ident[slot];
        ph        = random_phase();
        if (roll < w_create)
            r = make_req(REQ_CREATE, $urandom, ph);
        else if (roll < w_create + 25)
        begin
            // mostly the next phase up so witnesses walk to completion
            if (slot >= 0 && tbl_phase[slot] != PH_COMPLETED && $urandom_range(0, 9) < 6)
                ph = tbl_phase[slot] + 1'b1;
            r = make_req(REQ_ADVANCE, id, ph);
        end
        else if (roll < w_create + 25 + w_release)
            r = make_req(REQ_RELEASE, id, ph);
        else if (roll < 90)
            r = make_req(REQ_QUERY, id, ph);
        else
        begin
            case ($urandom_range(0, 3))
                0: id = '0;
                1: id = (retired_ids.size() != 0) ?
                        retired_ids[$urandom_range(0, retired_ids.size() - 1)] : '1;
                2: id = '1;
                default: id = $urandom;
            endcase
            r = make_req(REQ_W'($urandom_range(0, 3)), id, ph);
        end
        return r;
    endfunction

    // ------------------------------------------------------------- driving
    task automatic send_req(input witness_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0)
            begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        req_ch.valid         = 1'b1;
        req_ch.req_type      = r.req_type;
        req_ch.witness_id    = r.witness_id;
        req_ch.target_phase  = r.target_phase;
        req_ch.reason_kind   = r.reason_kind;
        req_ch.reason_time   = r.reason_time;
        req_ch.reason_region = r.reason_region;
        req_ch.reason_task   = r.reason_task;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        expected_rsp_q.push_back(apply_witness_req(r));
        reqs_sent++;
        @(negedge clk);
    endtask

    // drop valid and wait for every outstanding response
    task automatic drain();
        req_ch.valid = 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver: alternating stall/run pattern plus requested long hold-offs
    initial
    begin
        int  run;
        int  held;
        bit  stalling;
        rsp_ch.ready = 1'b0;
        hold_served  = 0;
        run          = 0;
        held         = 0;
        stalling     = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                held        = HOLD_CYCLES;
            end
            if (held > 0)
            begin
                rsp_ch.ready = 1'b0;
                held--;
            end
            else
            begin
                if (run == 0)
                begin
                    stalling = !stalling;
                    if (stalling)
                        run = $urandom_range(1, 20);
                    else
                        run = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 600)
                                                          : $urandom_range(1, 40);
                end
                rsp_ch.ready = !stalling;
                run--;
            end
        end
    end

    // ------------------------------------------------------------- checking
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR: response %0d, %s: got %0h, expected %0h",
                 rsp_checked, what, got, want);
        mismatches++;
    endtask

    initial
    begin
        rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (expected_rsp_q.size() == 0)
                    report_mismatch("response with no request pending",
                                    64'(rsp_ch.status), '0);
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
                    if (rsp_ch.new_id !== want.new_id)
                        report_mismatch("new_id", 64'(rsp_ch.new_id), 64'(want.new_id));
                    if (rsp_ch.cur_phase !== want.cur_phase)
                        report_mismatch("cur_phase", 64'(rsp_ch.cur_phase),
                                        64'(want.cur_phase));
                    if (rsp_ch.out_kind !== want.out_kind)
                        report_mismatch("out_kind", 64'(rsp_ch.out_kind),
                                        64'(want.out_kind));
                    if (rsp_ch.out_time !== want.out_time)
                        report_mismatch("out_time", rsp_ch.out_time, want.out_time);
                    if (rsp_ch.out_region !== want.out_region)
                        report_mismatch("out_region", 64'(rsp_ch.out_region),
                                        64'(want.out_region));
                    if (rsp_ch.out_task !== want.out_task)
                        report_mismatch("out_task", 64'(rsp_ch.out_task),
                                        64'(want.out_task));
                    if (rsp_ch.found !== want.found)
                        report_mismatch("found", 64'(rsp_ch.found), 64'(want.found));
                end
                rsp_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- tests
    task automatic test_lookup_misses();
        send_req(make_req(REQ_QUERY, 32'd1, PH_REQUESTED));
        send_req(make_req(REQ_ADVANCE, '0, PH_COMPLETED));
        send_req(make_req(REQ_RELEASE, '0, PH_CANCELLING));
        send_req(make_req(REQ_QUERY, '1, PH_COMPLETED));
    endtask

    // ids 1, 2 and 3 follow from the counter starting at one after reset
    task automatic test_life_cycle();
        witness_req_t r;
        r = make_req(REQ_CREATE, '1, PH_COMPLETED);
        r.reason_kind   = '1;
        r.reason_time   = '1;
        r.reason_region = '1;
        r.reason_task   = '1;
        send_req(r);
        r = make_req(REQ_CREATE, '0, PH_REQUESTED);
        r.reason_kind   = '0;
        r.reason_time   = '0;
        r.reason_region = '0;
        r.reason_task   = '0;
        send_req(r);
        send_req(make_req(REQ_QUERY, 32'd1, PH_REQUESTED));
        send_req(make_req(REQ_QUERY, 32'd2, PH_REQUESTED));
        send_req(make_req(REQ_ADVANCE, 32'd2, PH_REQUESTED));
        send_req(make_req(REQ_ADVANCE, 32'd2, PH_FINALIZING));
        send_req(make_req(REQ_ADVANCE, 32'd2, PH_CANCELLING));
        send_req(make_req(REQ_ADVANCE, 32'd2, PH_COMPLETED));
        send_req(make_req(REQ_ADVANCE, 32'd2, PH_COMPLETED));
        send_req(make_req(REQ_QUERY, 32'd2, PH_REQUESTED));
        send_req(make_req(REQ_RELEASE, 32'd1, PH_REQUESTED));
        send_req(make_req(REQ_QUERY, 32'd1, PH_REQUESTED));
        send_req(make_req(REQ_RELEASE, 32'd1, PH_REQUESTED));
        send_req(make_req(REQ_ADVANCE, 32'd1, PH_CANCELLING));
        // slot 0 is free again and gets the next id
        send_req(make_req(REQ_CREATE, '0, PH_REQUESTED));
        send_req(make_req(REQ_QUERY, 32'd3, PH_REQUESTED));
    endtask

    task automatic test_table_full();
        int slot;
        while (count_live() < TABLE_SLOTS)
            send_req(make_req(REQ_CREATE, $urandom, random_phase()));
        send_req(make_req(REQ_CREATE, $urandom, random_phase()));
        send_req(make_req(REQ_QUERY, tbl_ident[TABLE_SLOTS-1], PH_REQUESTED));
        slot = TABLE_SLOTS / 2;
        send_req(make_req(REQ_RELEASE, tbl_ident[slot], PH_REQUESTED));
        send_req(make_req(REQ_CREATE, $urandom, random_phase()));
        send_req(make_req(REQ_QUERY, tbl_ident[slot], PH_REQUESTED));
        send_req(make_req(REQ_CREATE, $urandom, random_phase()));
    endtask

    // receiver holds off while requests keep coming, then a full drain
    task automatic test_backpressure();
        int i;
        drain();
        @(posedge clk);
        hold_requests++;
        @(negedge clk);
        for (i = 0; i < 8; i++)
            send_req(random_witness_req());
        drain();
    endtask

    task automatic test_random_traffic();
        int i;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_req(random_witness_req());
            if (i % 250 == 249)
                drain();
        end
    endtask

    initial
    begin
        int i;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_CREATE;
        req_ch.witness_id    = '0;
        req_ch.target_phase  = PH_REQUESTED;
        req_ch.reason_kind   = '0;
        req_ch.reason_time   = '0;
        req_ch.reason_region = '0;
        req_ch.reason_task   = '0;
        mismatches     = 0;
        rsp_checked    = 0;
        reqs_sent      = 0;
        burst_left     = 0;
        hold_requests  = 0;
        n_create_ok    = 0;
        n_exhausted    = 0;
        n_refused      = 0;
        n_released     = 0;
        n_query_hit    = 0;
        n_missing      = 0;
        tbl_high_water = 0;
        tbl_next_ident = ID_W'(1);
        for (i = 0; i < TABLE_SLOTS; i++)
            tbl_live[i] = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_lookup_misses();
        test_life_cycle();
        test_table_full();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (2 * SCAN_LATENCY) @(posedge clk);

        $display("Covered %0d requests: %0d creates, %0d on a full table, %0d refused advances,",
                 reqs_sent, n_create_ok, n_exhausted, n_refused);
        $display("  %0d releases, %0d query hits, %0d unknown ids; %0d responses checked.",
                 n_released, n_query_hit, n_missing, rsp_checked);
        if (mismatches == 0)
            $display("PASS witness_slot_table");
        else
            $display("FAIL witness_slot_table");
        $finish;
    end

endmodule

// ----- witness_slot_table.f -----
+incdir+hdl
hdl/wst_pkg.sv
hdl/wst_req_if.sv
hdl/wst_rsp_if.sv
hdl/wst_cell.sv
hdl/wst_chain.sv
hdl/witness_slot_table.sv
sim/tb.sv
